>>> rtl/core/gcl_pkg.sv
// shared types and constants for the greedy graph clusterer
package gcl_pkg;

    localparam logic [1:0] CMD_LOAD  = 2'd0;
    localparam logic [1:0] CMD_RUN   = 2'd1;
    localparam logic [1:0] CMD_CLEAR = 2'd2;
    localparam logic [1:0] CMD_NOP   = 2'd3;

    localparam logic [1:0] REG_NODE_COUNT = 2'd0;
    localparam logic [1:0] REG_SUPPORT    = 2'd1;
    localparam logic [1:0] REG_DENSITY    = 2'd2;

    localparam int SUPPORT_FRAC = 12;
    localparam int DENSITY_FRAC = 8;
    localparam int UNITY_Q88    = 256;

    typedef enum logic [15:0] {
        S_CLR      = 16'b0000_0000_0000_0001,
        S_IDLE     = 16'b0000_0000_0000_0010,
        S_LOAD1    = 16'b0000_0000_0000_0100,
        S_LOAD2    = 16'b0000_0000_0000_1000,
        S_RUN      = 16'b0000_0000_0001_0000,
        S_SEED     = 16'b0000_0000_0010_0000,
        S_SEED_SET = 16'b0000_0000_0100_0000,
        S_NBR      = 16'b0000_0000_1000_0000,
        S_GROW     = 16'b0000_0001_0000_0000,
        S_PICK     = 16'b0000_0010_0000_0000,
        S_MUL      = 16'b0000_0100_0000_0000,
        S_DECIDE   = 16'b0000_1000_0000_0000,
        S_JOIN     = 16'b0001_0000_0000_0000,
        S_OUT_RD   = 16'b0010_0000_0000_0000,
        S_OUT_LD   = 16'b0100_0000_0000_0000,
        S_OUT      = 16'b1000_0000_0000_0000
    } state_t;

endpackage

>>> rtl/core/gcl_ram.sv
// single write port, single registered read port memory
module gcl_ram #(
    parameter int DW = 8,
    parameter int AW = 6
) (
    input  logic          clk,
    input  logic          we,
    input  logic [AW-1:0] waddr,
    input  logic [DW-1:0] wdata,
    input  logic [AW-1:0] raddr,
    output logic [DW-1:0] rdata
);

    logic [DW-1:0] mem [(1 << AW)];

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        rdata <= mem[raddr];
    end

endmodule

>>> rtl/core/gcl_mult.sv
// shared unsigned multiplier with registered product
module gcl_mult #(
    parameter int OPW = 30
) (
    input  logic             clk,
    input  logic [OPW-1:0]   a,
    input  logic [OPW-1:0]   b,
    output logic [2*OPW-1:0] prod
);

    always_ff @(posedge clk)
    begin
        prod <= a * b;
    end

endmodule

>>> rtl/core/greedy_graph_clusterer.sv
// top level: edge store, greedy cluster sequencer and label output
//
//  channel | signals                                   | direction
//  input   | in_valid/in_ready, cmd node_a node_b      | in
//          | edge_weight                               |
//  output  | out_valid/out_ready, node_id cluster_id   | out
//          | last                                      |
//  config  | cfg_write cfg_index cfg_data              | in
//
// a load makes two writes into the weight memory, one per direction; cmd 3 does nothing.
// reset sweeps every entry of the weight memory to zero, and a clear item does the same
// and holds the block; no items are taken meanwhile.
// a run walks the n by n weight matrix one entry a cycle: a full scan per seed search and
// per candidate pick, then the multiply steps and decision; one row per neighbor
// scan, then one label per node, held during output stalls; no item is taken meanwhile.
module greedy_graph_clusterer #(
    parameter int MAX_NODES   = 64,
    parameter int WEIGHT_BITS = 16
) (
    input  logic                   clk,
    input  logic                   rst_n,
    input  logic                   in_valid,
    output logic                   in_ready,
    input  logic [1:0]             cmd,
    input  logic [6:0]             node_a,
    input  logic [6:0]             node_b,
    input  logic [WEIGHT_BITS-1:0] edge_weight,
    output logic                   out_valid,
    input  logic                   out_ready,
    output logic [6:0]             node_id,
    output logic [6:0]             cluster_id,
    output logic                   last,
    input  logic                   cfg_write,
    input  logic [1:0]             cfg_index,
    input  logic [15:0]            cfg_data
);
    import gcl_pkg::*;

    localparam int IW     = $clog2(MAX_NODES);
    localparam int CW     = $clog2(MAX_NODES + 1);
    localparam int AW     = 2 * IW;
    localparam int ACC_W  = WEIGHT_BITS + IW;
    localparam int SUM_W  = WEIGHT_BITS + 2 * IW;
    localparam int TDP_W  = 16 + 2 * CW;
    localparam int OPW    = (SUM_W > TDP_W) ? SUM_W : TDP_W;
    localparam int CMP_W  = 2 * OPW + SUPPORT_FRAC + 1;
    localparam int MDW    = WEIGHT_BITS + 1;

    state_t state_reg, state_next;

    logic [6:0]  node_count_reg, node_count_next;
    logic [15:0] ts_reg, ts_next;
    logic [15:0] td_reg, td_next;

    logic [IW-1:0]          a_reg, a_next, b_reg, b_next;
    logic [WEIGHT_BITS-1:0] w_reg, w_next;
    logic [WEIGHT_BITS-1:0] largest_reg, largest_next;
    logic [AW-1:0]          sweep_reg, sweep_next;

    logic [MAX_NODES-1:0] clustered_reg, clustered_next;
    logic [MAX_NODES-1:0] member_reg, member_next;
    logic [MAX_NODES-1:0] cand_reg, cand_next;
    logic [SUM_W-1:0]     wsum_reg, wsum_next;
    logic [CW-1:0]        size_reg, size_next;
    logic [CW-1:0]        done_reg, done_next;
    logic [6:0]           clusters_reg, clusters_next;

    // scan engine
    logic          scan_on_reg, scan_on_next;
    logic [IW-1:0] oi_reg, oi_next, ij_reg, ij_next;
    logic          d_valid_reg, d_valid_next;
    logic [IW-1:0] d_i_reg, d_i_next, d_j_reg, d_j_next;
    logic          d_lastj_reg, d_lastj_next;
    logic          d_end_reg, d_end_next;
    logic [ACC_W-1:0] acc_reg, acc_next;
    logic [ACC_W-1:0] best_reg, best_next;
    logic [IW-1:0]    bi_reg, bi_next;
    logic             found_reg, found_next;

    logic [2:0]         step_reg, step_next;
    logic [2*OPW-1:0]   p1_reg, p1_next, p2_reg, p2_next, p4_reg, p4_next;
    logic [OPW-1:0]     mul_a, mul_b;
    logic [2*OPW-1:0]   mul_p;

    logic [IW-1:0] oidx_reg, oidx_next;
    logic          ovalid_reg, ovalid_next;
    logic [6:0]    oid_reg, oid_next, ocl_reg, ocl_next;
    logic          olast_reg, olast_next;

    // memory ports
    logic            wm_we;
    logic [AW-1:0]   wm_waddr;
    logic [MDW-1:0]  wm_wdata;
    logic [MDW-1:0]  wm_rdata;
    logic            lm_we;
    logic [IW-1:0]   lm_waddr;
    logic [6:0]      lm_wdata;
    logic [IW-1:0]   lm_raddr;
    logic [6:0]      lm_rdata;

    logic [CW-1:0]  n_act;
    logic [IW-1:0]  last_idx;
    logic           ld_ok;
    logic           present;
    logic [WEIGHT_BITS-1:0] wt;
    logic [ACC_W-1:0] contrib, row_sum;
    logic           row_ok;
    logic [OPW-1:0] norm;
    logic           sup_pass, den_pass;
    logic           scan_single;

    gcl_ram #(.DW(MDW), .AW(AW)) u_wmem (
        .clk   (clk),
        .we    (wm_we),
        .waddr (wm_waddr),
        .wdata (wm_wdata),
        .raddr ({oi_reg, ij_reg}),
        .rdata (wm_rdata)
    );

    gcl_ram #(.DW(7), .AW(IW)) u_lmem (
        .clk   (clk),
        .we    (lm_we),
        .waddr (lm_waddr),
        .wdata (lm_wdata),
        .raddr (lm_raddr),
        .rdata (lm_rdata)
    );

    gcl_mult #(.OPW(OPW)) u_mult (
        .clk  (clk),
        .a    (mul_a),
        .b    (mul_b),
        .prod (mul_p)
    );

    always_comb
    begin
        if (node_count_reg == 7'd0)
        begin
            n_act = CW'(1);
        end
        else if (32'(node_count_reg) > MAX_NODES)
        begin
            n_act = CW'(MAX_NODES);
        end
        else
        begin
            n_act = CW'(node_count_reg);
        end
    end

    assign last_idx = IW'(n_act - CW'(1));
    assign present  = wm_rdata[WEIGHT_BITS];
    assign wt       = wm_rdata[WEIGHT_BITS-1:0];
    assign norm     = (OPW'(largest_reg) > OPW'(UNITY_Q88)) ? OPW'(largest_reg)
                                                             : OPW'(UNITY_Q88);
    assign ld_ok    = (node_a != 7'd0) && (32'(node_a) <= MAX_NODES) &&
                      (node_b != 7'd0) && (32'(node_b) <= MAX_NODES) &&
                      (node_a != node_b);

    assign sup_pass = (CMP_W'(p1_reg) << SUPPORT_FRAC) >= (CMP_W'(p2_reg) << 1);
    assign den_pass = (CMP_W'(SUM_W'(wsum_reg + SUM_W'(best_reg))) << DENSITY_FRAC)
                      > CMP_W'(p4_reg);

    assign scan_single = (state_reg == S_NBR);

    // per-row evaluation of the entry coming out of the weight memory
    always_comb
    begin
        contrib = '0;
        row_ok  = 1'b0;
        case (state_reg)
            S_SEED:
            begin
                row_ok = !clustered_reg[d_i_reg];
                if (present && (d_j_reg != d_i_reg) && !clustered_reg[d_j_reg])
                begin
                    contrib = ACC_W'(wt);
                end
            end
            S_PICK:
            begin
                row_ok = cand_reg[d_i_reg];
                if (member_reg[d_j_reg])
                begin
                    contrib = ACC_W'(wt);
                end
            end
            default:
            begin
                contrib = '0;
                row_ok  = 1'b0;
            end
        endcase
        row_sum = ((d_j_reg == '0) ? '0 : acc_reg) + contrib;
    end

    always_comb
    begin
        mul_a = '0;
        mul_b = '0;
        if (state_reg == S_MUL)
        begin
            case (step_reg)
                3'd0:
                begin
                    mul_a = OPW'(best_reg);
                    mul_b = OPW'(size_reg - CW'(1));
                end
                3'd1:
                begin
                    mul_a = OPW'(ts_reg);
                    mul_b = OPW'(wsum_reg);
                end
                3'd2:
                begin
                    mul_a = OPW'(size_reg) + OPW'(1);
                    mul_b = OPW'(size_reg);
                end
                3'd3:
                begin
                    mul_a = OPW'(td_reg);
                    mul_b = OPW'(mul_p >> 1);
                end
                3'd4:
                begin
                    mul_a = norm;
                    mul_b = OPW'(mul_p);
                end
                default:
                begin
                    mul_a = '0;
                    mul_b = '0;
                end
            endcase
        end
    end

    always_comb
    begin
        state_next     = state_reg;
        node_count_next = node_count_reg;
        ts_next        = ts_reg;
        td_next        = td_reg;
        a_next         = a_reg;
        b_next         = b_reg;
        w_next         = w_reg;
        largest_next   = largest_reg;
        sweep_next     = sweep_reg;
        clustered_next = clustered_reg;
        member_next    = member_reg;
        cand_next      = cand_reg;
        wsum_next      = wsum_reg;
        size_next      = size_reg;
        done_next      = done_reg;
        clusters_next  = clusters_reg;
        scan_on_next   = 1'b0;
        oi_next        = oi_reg;
        ij_next        = ij_reg;
        acc_next       = acc_reg;
        best_next      = best_reg;
        bi_next        = bi_reg;
        found_next     = found_reg;
        step_next      = step_reg;
        p1_next        = p1_reg;
        p2_next        = p2_reg;
        p4_next        = p4_reg;
        oidx_next      = oidx_reg;
        ovalid_next    = ovalid_reg;
        oid_next       = oid_reg;
        ocl_next       = ocl_reg;
        olast_next     = olast_reg;
        wm_we          = 1'b0;
        wm_waddr       = sweep_reg;
        wm_wdata       = '0;
        lm_we          = 1'b0;
        lm_waddr       = bi_reg;
        lm_wdata       = clusters_reg;
        lm_raddr       = oidx_reg;
        in_ready       = (state_reg == S_IDLE);

        if (cfg_write)
        begin
            case (cfg_index)
                REG_NODE_COUNT: node_count_next = cfg_data[6:0];
                REG_SUPPORT:    ts_next = cfg_data;
                REG_DENSITY:    td_next = cfg_data;
                default:        ;
            endcase
        end

        // scan issue side
        d_valid_next = scan_on_reg;
        d_i_next     = oi_reg;
        d_j_next     = ij_reg;
        d_lastj_next = (ij_reg == last_idx);
        d_end_next   = scan_on_reg && (ij_reg == last_idx) &&
                       (scan_single || (oi_reg == last_idx));
        if (scan_on_reg)
        begin
            scan_on_next = 1'b1;
            if (ij_reg == last_idx)
            begin
                ij_next = '0;
                if (scan_single || (oi_reg == last_idx))
                begin
                    scan_on_next = 1'b0;
                end
                else
                begin
                    oi_next = oi_reg + IW'(1);
                end
            end
            else
            begin
                ij_next = ij_reg + IW'(1);
            end
        end

        // scan data side
        if (d_valid_reg && ((state_reg == S_SEED) || (state_reg == S_PICK)))
        begin
            acc_next = row_sum;
            if (d_lastj_reg && row_ok && (!found_reg || (row_sum > best_reg)))
            begin
                found_next = 1'b1;
                best_next  = row_sum;
                bi_next    = d_i_reg;
            end
        end
        if (d_valid_reg && (state_reg == S_NBR))
        begin
            if (present && (d_j_reg != d_i_reg) && !clustered_reg[d_j_reg])
            begin
                cand_next[d_j_reg] = 1'b1;
            end
        end

        case (state_reg)
            S_CLR:
            begin
                wm_we        = 1'b1;
                wm_waddr     = sweep_reg;
                wm_wdata     = '0;
                largest_next = '0;
                sweep_next   = sweep_reg + AW'(1);
                if (sweep_reg == '1)
                begin
                    state_next = S_IDLE;
                end
            end
            S_IDLE:
            begin
                if (in_valid)
                begin
                    a_next = IW'(node_a - 7'd1);
                    b_next = IW'(node_b - 7'd1);
                    w_next = edge_weight;
                    case (cmd)
                        CMD_LOAD:  state_next = ld_ok ? S_LOAD1 : S_IDLE;
                        CMD_RUN:   state_next = S_RUN;
                        CMD_CLEAR:
                        begin
                            sweep_next = '0;
                            state_next = S_CLR;
                        end
                        default:   state_next = S_IDLE;
                    endcase
                end
            end
            S_LOAD1:
            begin
                wm_we    = 1'b1;
                wm_waddr = {a_reg, b_reg};
                wm_wdata = {1'b1, w_reg};
                if (w_reg > largest_reg)
                begin
                    largest_next = w_reg;
                end
                state_next = S_LOAD2;
            end
            S_LOAD2:
            begin
                wm_we      = 1'b1;
                wm_waddr   = {b_reg, a_reg};
                wm_wdata   = {1'b1, w_reg};
                state_next = S_IDLE;
            end
            S_RUN:
            begin
                clustered_next = '0;
                clusters_next  = '0;
                done_next      = '0;
                scan_on_next   = 1'b1;
                oi_next        = '0;
                ij_next        = '0;
                found_next     = 1'b0;
                state_next     = S_SEED;
            end
            S_SEED:
            begin
                if (d_valid_reg && d_end_reg)
                begin
                    state_next = S_SEED_SET;
                end
            end
            S_SEED_SET:
            begin
                clusters_next           = clusters_reg + 7'd1;
                lm_we                   = 1'b1;
                lm_waddr                = bi_reg;
                lm_wdata                = clusters_reg + 7'd1;
                clustered_next[bi_reg]  = 1'b1;
                member_next             = '0;
                member_next[bi_reg]     = 1'b1;
                wsum_next               = '0;
                size_next               = CW'(1);
                done_next               = done_reg + CW'(1);
                cand_next               = '0;
                scan_on_next            = 1'b1;
                oi_next                 = bi_reg;
                ij_next                 = '0;
                state_next              = S_NBR;
            end
            S_NBR:
            begin
                if (d_valid_reg && d_end_reg)
                begin
                    state_next = S_GROW;
                end
            end
            S_GROW:
            begin
                if (cand_reg == '0)
                begin
                    if (done_reg == n_act)
                    begin
                        oidx_next  = '0;
                        state_next = S_OUT_RD;
                    end
                    else
                    begin
                        scan_on_next = 1'b1;
                        oi_next      = '0;
                        ij_next      = '0;
                        found_next   = 1'b0;
                        state_next   = S_SEED;
                    end
                end
                else
                begin
                    scan_on_next = 1'b1;
                    oi_next      = '0;
                    ij_next      = '0;
                    found_next   = 1'b0;
                    state_next   = S_PICK;
                end
            end
            S_PICK:
            begin
                if (d_valid_reg && d_end_reg)
                begin
                    step_next  = '0;
                    state_next = S_MUL;
                end
            end
            S_MUL:
            begin
                // product of the previous step is in mul_p
                step_next = step_reg + 3'd1;
                case (step_reg)
                    3'd1:    p1_next = mul_p;
                    3'd2:    p2_next = mul_p;
                    3'd5:
                    begin
                        p4_next    = mul_p;
                        state_next = S_DECIDE;
                    end
                    default: ;
                endcase
            end
            S_DECIDE:
            begin
                if (sup_pass && den_pass)
                begin
                    state_next = S_JOIN;
                end
                else if (done_reg == n_act)
                begin
                    oidx_next  = '0;
                    state_next = S_OUT_RD;
                end
                else
                begin
                    scan_on_next = 1'b1;
                    oi_next      = '0;
                    ij_next      = '0;
                    found_next   = 1'b0;
                    state_next   = S_SEED;
                end
            end
            S_JOIN:
            begin
                wsum_next              = wsum_reg + SUM_W'(best_reg);
                member_next[bi_reg]    = 1'b1;
                size_next              = size_reg + CW'(1);
                done_next              = done_reg + CW'(1);
                lm_we                  = 1'b1;
                lm_waddr               = bi_reg;
                lm_wdata               = clusters_reg;
                clustered_next[bi_reg] = 1'b1;
                cand_next[bi_reg]      = 1'b0;
                scan_on_next           = 1'b1;
                oi_next                = bi_reg;
                ij_next                = '0;
                state_next             = S_NBR;
            end
            S_OUT_RD:
            begin
                state_next = S_OUT_LD;
            end
            S_OUT_LD:
            begin
                ovalid_next = 1'b1;
                oid_next    = 7'(oidx_reg) + 7'd1;
                ocl_next    = lm_rdata;
                olast_next  = (oidx_reg == last_idx);
                state_next  = S_OUT;
            end
            S_OUT:
            begin
                if (out_ready)
                begin
                    ovalid_next = 1'b0;
                    if (olast_reg)
                    begin
                        state_next = S_IDLE;
                    end
                    else
                    begin
                        oidx_next  = oidx_reg + IW'(1);
                        state_next = S_OUT_RD;
                    end
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg      <= S_CLR;
            node_count_reg <= 7'd64;
            ts_reg         <= 16'd2048;
            td_reg         <= 16'd0;
            largest_reg    <= '0;
            sweep_reg      <= '0;
            scan_on_reg    <= 1'b0;
            d_valid_reg    <= 1'b0;
            d_end_reg      <= 1'b0;
            found_reg      <= 1'b0;
            step_reg       <= '0;
            ovalid_reg     <= 1'b0;
            clustered_reg  <= '0;
            member_reg     <= '0;
            cand_reg       <= '0;
            wsum_reg       <= '0;
            size_reg       <= '0;
            done_reg       <= '0;
            clusters_reg   <= '0;
        end
        else
        begin
            state_reg      <= state_next;
            node_count_reg <= node_count_next;
            ts_reg         <= ts_next;
            td_reg         <= td_next;
            largest_reg    <= largest_next;
            sweep_reg      <= sweep_next;
            scan_on_reg    <= scan_on_next;
            d_valid_reg    <= d_valid_next;
            d_end_reg      <= d_end_next;
            found_reg      <= found_next;
            step_reg       <= step_next;
            ovalid_reg     <= ovalid_next;
            clustered_reg  <= clustered_next;
            member_reg     <= member_next;
            cand_reg       <= cand_next;
            wsum_reg       <= wsum_next;
            size_reg       <= size_next;
            done_reg       <= done_next;
            clusters_reg   <= clusters_next;
        end
    end

    always_ff @(posedge clk)
    begin
        a_reg       <= a_next;
        b_reg       <= b_next;
        w_reg       <= w_next;
        oi_reg      <= oi_next;
        ij_reg      <= ij_next;
        d_i_reg     <= d_i_next;
        d_j_reg     <= d_j_next;
        d_lastj_reg <= d_lastj_next;
        acc_reg     <= acc_next;
        best_reg    <= best_next;
        bi_reg      <= bi_next;
        p1_reg      <= p1_next;
        p2_reg      <= p2_next;
        p4_reg      <= p4_next;
        oidx_reg    <= oidx_next;
        oid_reg     <= oid_next;
        ocl_reg     <= ocl_next;
        olast_reg   <= olast_next;
    end

    assign out_valid  = ovalid_reg;
    assign node_id    = oid_reg;
    assign cluster_id = ocl_reg;
    assign last       = olast_reg;

endmodule
